// ===== hdl/rvs_pkg.sv =====
package rvs_pkg;

   // Binary point position of every direction, normal and index value.
   localparam int FRAC_BITS = 14;

   localparam int IN_W  = 16;
   localparam int OUT_W = 16;
   localparam int REQ_W = 8 * IN_W;
   localparam int RSP_W = 3 * OUT_W;

   function automatic int imax(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Internal widths, all derived from the input width and the binary point position.
   localparam int DOT_W  = 2 * IN_W + 2;
   localparam int C_W    = DOT_W - FRAC_BITS + 1;
   localparam int CC_W   = 2 * C_W;
   localparam int SX_W   = imax(CC_W, 2 * FRAC_BITS + 1) + 2;
   localparam int S_W    = imax(CC_W - FRAC_BITS, FRAC_BITS) + 2;
   localparam int J_W    = FRAC_BITS + 2;
   localparam int JSQ_W  = 2 * J_W + 1;
   localparam int JJ_W   = J_W + 3;
   localparam int JS_W   = JJ_W + S_W + 1;
   localparam int K_W    = 2 * ((JS_W + 1) / 2);
   localparam int SQ_N   = K_W / 2;
   localparam int Q_W    = SQ_N + 1;
   localparam int JC_W   = J_W + 1 + C_W;
   localparam int MD_W   = imax(JC_W, Q_W + FRAC_BITS + 1) + 2;
   localparam int M_W    = MD_W - FRAC_BITS + 1;
   localparam int JD_W   = J_W + 1 + IN_W;
   localparam int NM_W   = IN_W + M_W;
   localparam int RS_W   = imax(JD_W, NM_W) + 2;
   localparam int MP_W   = DOT_W + IN_W;
   localparam int MPX_W  = imax(MP_W, 2 * FRAC_BITS) + 1;
   localparam int MR_W   = imax(MPX_W - 2 * FRAC_BITS + 3, IN_W + 2);
   localparam int R_W    = imax(RS_W - FRAC_BITS + 1, MR_W);
   localparam int DVD_W  = IN_W + FRAC_BITS + 1;

   // Stage offsets that place the quotient and the root along the top pipeline.
   localparam int DIV_LAT = J_W + 1;
   localparam int SQ_LAT  = SQ_N + 1;

   typedef logic [2:0][IN_W-1:0] vec3_type;
   typedef logic [2:0][R_W-1:0]  res3_type;

endpackage

// ===== hdl/rvs_div.sv =====
module rvs_div (
   input  logic                      clock,
   input  logic                      en,
   input  logic [rvs_pkg::IN_W-1:0]  num,
   input  logic [rvs_pkg::IN_W-1:0]  den,
   output logic [rvs_pkg::J_W-1:0]   quo
);
   import rvs_pkg::*;

   // Rounded quotient num * 2^F / den, one quotient bit per stage, saturated.
   logic [DVD_W-1:0] dvd;
   logic             ovf_in;

   logic [IN_W-1:0] den_ff [0:J_W];
   logic            ovf_ff [0:J_W];
   logic [IN_W-1:0] rem_ff [0:J_W];
   logic [J_W-1:0]  low_ff [0:J_W];
   logic [J_W-1:0]  quo_ff [0:J_W];

   logic [IN_W-1:0] rem_in [1:J_W];
   logic [J_W-1:0]  low_in [1:J_W];
   logic [J_W-1:0]  quo_in [1:J_W];

   assign dvd    = DVD_W'({num, FRAC_BITS'(0)}) + DVD_W'(den >> 1);
   // The quotient fits in J_W bits exactly when dvd < den * 2^J_W.
   assign ovf_in = {1'b0, dvd} >= {den, J_W'(0)};

   always_comb begin
      logic [IN_W:0] tr;
      tr = '0;
      for (int i = 1; i <= J_W; i++) begin
         tr = {rem_ff[i-1], low_ff[i-1][J_W-1]};
         low_in[i] = {low_ff[i-1][J_W-2:0], 1'b0};
         if (tr >= {1'b0, den_ff[i-1]}) begin
            rem_in[i] = IN_W'(tr - {1'b0, den_ff[i-1]});
            quo_in[i] = {quo_ff[i-1][J_W-2:0], 1'b1};
         end else begin
            rem_in[i] = IN_W'(tr);
            quo_in[i] = {quo_ff[i-1][J_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0] <= den;
         ovf_ff[0] <= ovf_in;
         rem_ff[0] <= IN_W'(dvd >> J_W);
         low_ff[0] <= dvd[J_W-1:0];
         quo_ff[0] <= '0;
         for (int i = 1; i <= J_W; i++) begin
            den_ff[i] <= den_ff[i-1];
            ovf_ff[i] <= ovf_ff[i-1];
            rem_ff[i] <= rem_in[i];
            low_ff[i] <= low_in[i];
            quo_ff[i] <= quo_in[i];
         end
      end
   end

   assign quo = ovf_ff[J_W] ? '1 : quo_ff[J_W];

endmodule

// ===== hdl/rvs_sqrt.sv =====
module rvs_sqrt (
   input  logic                     clock,
   input  logic                     en,
   input  logic [rvs_pkg::K_W-1:0]  rad,
   output logic [rvs_pkg::Q_W-1:0]  root
);
   import rvs_pkg::*;

   // Digit-by-digit square root, one root bit per stage, then rounding.
   logic [K_W-1:0]    rad_ff  [0:SQ_N];
   logic [SQ_N-1:0]   root_ff [0:SQ_N];
   logic [SQ_N+1:0]   rem_ff  [0:SQ_N];
   logic [Q_W-1:0]    q_ff;

   logic [K_W-1:0]    rad_in  [1:SQ_N];
   logic [SQ_N-1:0]   root_in [1:SQ_N];
   logic [SQ_N+1:0]   rem_in  [1:SQ_N];

   always_comb begin
      logic [SQ_N+3:0] tr;
      logic [SQ_N+3:0] trial;
      tr    = '0;
      trial = '0;
      for (int i = 1; i <= SQ_N; i++) begin
         tr        = {rem_ff[i-1], rad_ff[i-1][K_W-1:K_W-2]};
         trial     = (SQ_N+4)'({root_ff[i-1], 2'b01});
         rad_in[i] = {rad_ff[i-1][K_W-3:0], 2'b00};
         if (tr >= trial) begin
            rem_in[i]  = (SQ_N+2)'(tr - trial);
            root_in[i] = {root_ff[i-1][SQ_N-2:0], 1'b1};
         end else begin
            rem_in[i]  = (SQ_N+2)'(tr);
            root_in[i] = {root_ff[i-1][SQ_N-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0]  <= rad;
         root_ff[0] <= '0;
         rem_ff[0]  <= '0;
         for (int i = 1; i <= SQ_N; i++) begin
            rad_ff[i]  <= rad_in[i];
            root_ff[i] <= root_in[i];
            rem_ff[i]  <= rem_in[i];
         end
         // Round to nearest: the remainder exceeds the root exactly when
         // the radicand lies at or above (root + 1/2)^2.
         if (rem_ff[SQ_N] > (SQ_N+2)'(root_ff[SQ_N])) begin
            q_ff <= Q_W'(root_ff[SQ_N]) + Q_W'(1);
         end else begin
            q_ff <= Q_W'(root_ff[SQ_N]);
         end
      end
   end

   assign root = q_ff;

endmodule

// ===== hdl/refract_vector_snell.sv =====
// Refraction of a ray direction at a surface by Snell's law, in fixed point.
//
// Input channel (req_): one item carries the ray direction, the surface
// normal (signed Q2.14 each) and the refraction indices outside and inside
// (unsigned Q2.14). Result channel (rsp_): the new direction in signed
// Q2.14, saturated to [-2, 2), with two flags in rsp_tuser: total internal
// reflection (the mirror direction was returned) and clipping.
//
// The datapath is a pipeline of 49 register stages. One item may enter every
// cycle and one result leaves every cycle while the output is not stalled, so
// throughput is then one item per clock. The depth comes from the index
// divider (one quotient bit per stage, 17 stages), which runs alongside the
// front end, and the square root unit (one root bit per stage plus rounding),
// with multiplier stages between the two and after the square root.
//
// The last stage is the output register. When the receiver holds rsp_tready
// low while a result waits, the whole pipeline freezes and req_tready drops;
// nothing is lost or repeated, and bubbles stay in place.
// Reset clears the valid bit of every stage; data registers keep no reset.
module refract_vector_snell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_inside, index_outside
   input  logic [rvs_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // out_x, out_y, out_z
   output logic [rvs_pkg::RSP_W-1:0]  rsp_tdata,
   // total_reflect, clipped
   output logic [1:0]                 rsp_tuser
);
   import rvs_pkg::*;

   // Stage numbers along the pipeline.
   localparam int ST_A  = 5;
   localparam int ST_J  = DIV_LAT;
   localparam int ST_JJ = ST_J + 1;
   localparam int ST_JS = ST_J + 2;
   localparam int ST_K  = ST_J + 3;
   localparam int ST_Q  = ST_K + SQ_LAT;
   localparam int ST_M  = ST_Q + 1;
   localparam int ST_P  = ST_Q + 2;
   localparam int LAT   = ST_Q + 3;

   localparam int HALF_F = 2 ** (FRAC_BITS - 1);
   localparam logic signed [SX_W-1:0]  ONE_SX  = SX_W'(1) << (2 * FRAC_BITS);
   localparam logic signed [JS_W-1:0]  ONE_JS  = JS_W'(1) << (2 * FRAC_BITS);
   localparam logic signed [MPX_W-1:0] HALF_MP = MPX_W'(1) << (2 * FRAC_BITS - 2);

   // Values that wait for the index ratio.
   typedef struct packed {
      vec3_type               d;
      vec3_type               n;
      logic signed [C_W-1:0]  c;
      logic signed [S_W-1:0]  s;
      res3_type               mr;
   } wait_type;

   // Values that travel alongside the square root.
   typedef struct packed {
      vec3_type                d;
      vec3_type                n;
      logic [J_W-1:0]          j;
      logic signed [JC_W-1:0]  jc;
      res3_type                mr;
   } carry_type;

   logic            en;
   logic [LAT:1]    vld_ff;

   vec3_type        dv_ff [1:4];
   vec3_type        nv_ff [1:4];
   logic signed [2*IN_W-1:0] pr_ff [3];
   logic signed [DOT_W-1:0]  dot_ff;
   logic signed [C_W-1:0]    c3_ff;
   logic signed [C_W-1:0]    c4_ff;
   logic signed [MP_W-1:0]   mp_ff [3];
   logic signed [CC_W-1:0]   cc_ff;
   res3_type                 mr4_ff;
   wait_type                 a_ff [ST_A:ST_J];

   carry_type                cr_ff [ST_JJ:ST_P];
   logic [JJ_W-1:0]          jj_ff;
   logic signed [S_W-1:0]    s_jj_ff;
   logic signed [S_W-1:0]    s_js_ff;
   logic signed [JS_W-1:0]   js_ff;
   logic                     tir_ff [ST_K:ST_P];
   logic signed [M_W-1:0]    m_ff;
   logic signed [JD_W-1:0]   jd_ff [3];
   logic signed [NM_W-1:0]   nm_ff [3];

   logic [2:0][OUT_W-1:0]    out_ff;
   logic                     tir_out_ff;
   logic                     clip_ff;

   // Combinational next values.
   vec3_type                 dv_in;
   vec3_type                 nv_in;
   logic signed [2*IN_W-1:0] pr_in [3];
   logic signed [DOT_W-1:0]  dot_in;
   logic signed [C_W-1:0]    c3_in;
   logic signed [MP_W-1:0]   mp_in [3];
   logic signed [CC_W-1:0]   cc_in;
   res3_type                 mr4_in;
   wait_type                 a_in;
   logic [J_W-1:0]           quo;
   carry_type                cr_in;
   logic [JJ_W-1:0]          jj_in;
   logic signed [JS_W-1:0]   js_in;
   logic                     tir_in;
   logic [K_W-1:0]           k_in;
   logic [Q_W-1:0]           q;
   logic signed [M_W-1:0]    m_in;
   logic signed [JD_W-1:0]   jd_in [3];
   logic signed [NM_W-1:0]   nm_in [3];
   logic [2:0][OUT_W-1:0]    out_in;
   logic                     clip_in;

   // The pipeline advances whenever the output register is free or is read.
   assign en         = !vld_ff[LAT] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-1:1], req_tvalid};
      end
   end

   // Front end: products of the dot product, then its sum, then c and the
   // mirror products, then c squared and the mirror direction, then s.
   always_comb begin
      logic signed [DOT_W-1:0] cx;
      logic signed [MPX_W-1:0] mx;
      logic signed [SX_W-1:0]  sx;
      for (int i = 0; i < 3; i++) begin
         dv_in[i] = req_tdata[i*IN_W +: IN_W];
         nv_in[i] = req_tdata[(i+3)*IN_W +: IN_W];
         pr_in[i] = (2*IN_W)'($signed(dv_in[i])) * (2*IN_W)'($signed(nv_in[i]));
      end
      dot_in = DOT_W'(pr_ff[0]) + DOT_W'(pr_ff[1]) + DOT_W'(pr_ff[2]);
      cx     = (-dot_ff + DOT_W'(HALF_F)) >>> FRAC_BITS;
      c3_in  = C_W'(cx);
      for (int i = 0; i < 3; i++) begin
         mp_in[i] = MP_W'(dot_ff) * MP_W'($signed(nv_ff[2][i]));
      end
      cc_in = CC_W'(c3_ff) * CC_W'(c3_ff);
      // Mirror: d - round(2 * dot * n / 2^(2F)).
      for (int i = 0; i < 3; i++) begin
         mx        = (MPX_W'(mp_ff[i]) + HALF_MP) >>> (2 * FRAC_BITS - 1);
         mr4_in[i] = R_W'(R_W'($signed(dv_ff[3][i])) - R_W'(mx));
      end
      sx     = ONE_SX - SX_W'(cc_ff) + SX_W'(HALF_F);
      a_in.d  = dv_ff[4];
      a_in.n  = nv_ff[4];
      a_in.c  = c4_ff;
      a_in.s  = S_W'(sx >>> FRAC_BITS);
      a_in.mr = mr4_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[1] <= dv_in;
         nv_ff[1] <= nv_in;
         for (int i = 2; i <= 4; i++) begin
            dv_ff[i] <= dv_ff[i-1];
            nv_ff[i] <= nv_ff[i-1];
         end
         for (int i = 0; i < 3; i++) begin
            pr_ff[i] <= pr_in[i];
            mp_ff[i] <= mp_in[i];
         end
         dot_ff <= dot_in;
         c3_ff  <= c3_in;
         c4_ff  <= c3_ff;
         cc_ff  <= cc_in;
         mr4_ff <= mr4_in;
         a_ff[ST_A] <= a_in;
         for (int i = ST_A + 1; i <= ST_J; i++) begin
            a_ff[i] <= a_ff[i-1];
         end
      end
   end

   // Index ratio j = index_outside / index_inside, limited below 4.0.
   rvs_div u_div (
      .clock (clock),
      .en    (en),
      .num   (req_tdata[7*IN_W +: IN_W]),
      .den   (req_tdata[6*IN_W +: IN_W]),
      .quo   (quo)
   );

   // j squared, j * c, then j^2 * (1 - c^2), then k and the reflection test.
   always_comb begin
      logic [JSQ_W-1:0] jsq;
      jsq      = JSQ_W'(quo) * JSQ_W'(quo) + JSQ_W'(HALF_F);
      jj_in    = JJ_W'(jsq >> FRAC_BITS);
      cr_in.d  = a_ff[ST_J].d;
      cr_in.n  = a_ff[ST_J].n;
      cr_in.j  = quo;
      cr_in.jc = JC_W'($signed({1'b0, quo})) * JC_W'(a_ff[ST_J].c);
      cr_in.mr = a_ff[ST_J].mr;
      js_in    = JS_W'($signed({1'b0, jj_ff})) * JS_W'(s_jj_ff);
      // Total internal reflection needs 1 - c^2 > 0 and j^2 (1 - c^2) > 1.
      tir_in   = !s_js_ff[S_W-1] && (s_js_ff != '0) && (js_ff > ONE_JS);
      k_in     = K_W'(ONE_JS - js_ff);
   end

   rvs_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (k_in),
      .root  (q)
   );

   // m = round(j*c - sqrt(k)), then the products j*d and n*m.
   always_comb begin
      logic signed [MD_W-1:0] md;
      md   = MD_W'($signed(cr_ff[ST_Q].jc)) - MD_W'({q, FRAC_BITS'(0)})
             + MD_W'(HALF_F);
      m_in = M_W'(md >>> FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
         jd_in[i] = JD_W'($signed({1'b0, cr_ff[ST_M].j}))
                    * JD_W'($signed(cr_ff[ST_M].d[i]));
         nm_in[i] = NM_W'($signed(cr_ff[ST_M].n[i])) * NM_W'(m_ff);
      end
   end

   // Final sum, choice between refraction and mirror, and saturation.
   always_comb begin
      logic signed [RS_W-1:0] rs;
      logic [R_W-1:0]         rv;
      logic                   fits;
      clip_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         rs = RS_W'(jd_ff[i]) + RS_W'(nm_ff[i]) + RS_W'(HALF_F);
         if (tir_ff[ST_P]) begin
            rv = cr_ff[ST_P].mr[i];
         end else begin
            rv = R_W'(rs >>> FRAC_BITS);
         end
         fits = (&rv[R_W-1:OUT_W-1]) || !(|rv[R_W-1:OUT_W-1]);
         if (fits) begin
            out_in[i] = rv[OUT_W-1:0];
         end else begin
            clip_in   = 1'b1;
            out_in[i] = rv[R_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                  : {1'b0, {(OUT_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cr_ff[ST_JJ] <= cr_in;
         for (int i = ST_JJ + 1; i <= ST_P; i++) begin
            cr_ff[i] <= cr_ff[i-1];
         end
         jj_ff   <= jj_in;
         s_jj_ff <= a_ff[ST_J].s;
         s_js_ff <= s_jj_ff;
         js_ff   <= js_in;
         tir_ff[ST_K] <= tir_in;
         for (int i = ST_K + 1; i <= ST_P; i++) begin
            tir_ff[i] <= tir_ff[i-1];
         end
         m_ff <= m_in;
         for (int i = 0; i < 3; i++) begin
            jd_ff[i] <= jd_in[i];
            nm_ff[i] <= nm_in[i];
         end
         out_ff     <= out_in;
         tir_out_ff <= tir_ff[ST_P];
         clip_ff    <= clip_in;
      end
   end

   assign rsp_tvalid = vld_ff[LAT];
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = {clip_ff, tir_out_ff};

endmodule

// ===== hdl/rvs_chk.sv =====
module rvs_chk (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tready,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [rvs_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic [1:0]                 rsp_tuser
);
   import rvs_pkg::*;

   // A waiting result keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A stalled output freezes the pipeline, so no item may enter.
   a_stall_blocks: assert property (@(posedge clock)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item accepted while output stalled");

   // With the output register empty the block always takes an item.
   a_ready_empty: assert property (@(posedge clock)
      !rsp_tvalid |-> req_tready)
      else $error("not ready with empty output");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind refract_vector_snell rvs_chk u_rvs_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== sim/tb_refract_vector_snell.sv =====
module tb_refract_vector_snell;
   import rvs_pkg::*;

   localparam int FB = FRAC_BITS;
   // The pipeline is 49 stages deep; the drain wait allows for that and more.
   localparam int PIPE_DEPTH = 49;
   localparam longint CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [15:0] out_x, out_y, out_z;
      logic        total_reflect, clipped;
   } ray_out_type;

   typedef struct {
      logic [15:0] d[3];
      logic [15:0] n[3];
      logic [15:0] idx_in, idx_out;
      bit          has_known;
      ray_out_type known;
   } ray_in_type;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   refract_vector_snell DUT (.*);

   ray_out_type pending_dirs[$];
   ray_in_type  ray_queue[$];
   int       mismatch_count = 0;
   longint   cycle_count = 0;
   bit       stim_done = 0;
   bit       long_hold_go = 0;
   bit       long_hold_done = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Rounded right shift, ties toward plus infinity.
   function automatic longint rshr(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic longint isqrt_near(longint k);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--)
         if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= k)
            r += longint'(1) << b;
      // Round to nearest: root+1 if k - r^2 > r.
      if (k - r * r > r) r++;
      return r;
   endfunction

   function automatic ray_out_type refract_dir(ray_in_type t);
      longint d[3], n[3], r[3];
      longint jmax, j, jj, one, dot, c, s, k, q, m;
      ray_out_type o;
      bit tir, hit;
      jmax = (longint'(1) << (FB + 2)) - 1;
      one = longint'(1) << (2 * FB);
      dot = 0;
      hit = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'($signed(t.d[i]));
         n[i] = longint'($signed(t.n[i]));
         dot += d[i] * n[i];
      end
      if (t.idx_in == 0) j = jmax;
      else j = ((longint'(t.idx_out) << FB) + (t.idx_in >> 1)) / t.idx_in;
      if (j > jmax) j = jmax;
      jj = rshr(j * j, FB);
      c = rshr(-dot, FB);
      s = rshr(one - c * c, FB);
      tir = (s > 0) && (jj * s > one);
      if (tir) begin
         for (int i = 0; i < 3; i++) r[i] = d[i] - rshr(2 * dot * n[i], 2 * FB);
      end else begin
         k = one - jj * s;
         q = isqrt_near(k);
         m = rshr(j * c - (q << FB), FB);
         for (int i = 0; i < 3; i++) r[i] = rshr(j * d[i] + n[i] * m, FB);
      end
      for (int i = 0; i < 3; i++) begin
         if (r[i] > 32767) begin r[i] = 32767; hit = 1; end
         if (r[i] < -32768) begin r[i] = -32768; hit = 1; end
      end
      o.out_x = r[0][15:0];
      o.out_y = r[1][15:0];
      o.out_z = r[2][15:0];
      o.total_reflect = tir;
      o.clipped = hit;
      return o;
   endfunction

   function automatic ray_in_type mk_ray(int dx, int dy, int dz, int nx, int ny, int nz,
                                         int ii, int io);
      ray_in_type t;
      t.d[0] = 16'(dx); t.d[1] = 16'(dy); t.d[2] = 16'(dz);
      t.n[0] = 16'(nx); t.n[1] = 16'(ny); t.n[2] = 16'(nz);
      t.idx_in = 16'(ii); t.idx_out = 16'(io);
      t.has_known = 0;
      t.known = '0;
      return t;
   endfunction

   function automatic ray_in_type rand_ray(bit unit_like);
      ray_in_type t;
      for (int i = 0; i < 3; i++) begin
         if (unit_like) begin
            t.d[i] = 16'($signed($urandom_range(0, 32768)) - 16384);
            t.n[i] = 16'($signed($urandom_range(0, 32768)) - 16384);
         end else begin
            t.d[i] = 16'($urandom);
            t.n[i] = 16'($urandom);
         end
      end
      case ($urandom_range(0, 5))
         0: begin t.idx_in = 16'($urandom); t.idx_out = 16'($urandom); end
         1: begin t.idx_in = 16'($urandom_range(16384, 65535));
                  t.idx_out = 16'($urandom_range(16384, 65535)); end
         default: begin t.idx_in = 16'($urandom_range(16384, 24576));
                  t.idx_out = 16'($urandom_range(16384, 24576)); end
      endcase
      t.has_known = 0;
      t.known = '0;
      return t;
   endfunction

   // Directed table: extremes, both branches, and the named special cases.
   initial begin
      ray_in_type t;
      // Straight down through a plane of equal indices: output equals input.
      t = mk_ray(0, 0, -16384, 0, 0, 16384, 16384, 16384);
      t.has_known = 1; t.known = '{16'h0000, 16'h0000, 16'hC000, 1'b0, 1'b0};
      ray_queue.push_back(t);
      // Grazing ray from a dense medium: total internal reflection.
      ray_queue.push_back(mk_ray(16384, 0, 0, 0, 0, 16384, 16384, 32768));
      ray_queue.push_back(mk_ray(11585, 0, -11585, 0, 0, 16384, 16384, 24576));
      // Zero inside index takes j at its limit.
      ray_queue.push_back(mk_ray(0, 0, -16384, 0, 0, 16384, 0, 16384));
      ray_queue.push_back(mk_ray(1000, 2000, -3000, 0, 16384, 0, 0, 0));
      // Index ratio at the largest value that j can hold.
      ray_queue.push_back(mk_ray(5000, -5000, -14000, 0, 0, 16384, 16384, 65535));
      // Non-unit vectors where c*c >= 1.
      ray_queue.push_back(mk_ray(32767, 32767, 32767, 32767, 32767, 32767, 16384, 16384));
      ray_queue.push_back(mk_ray(-32768, -32768, -32768, 32767, 32767, 32767,
                                 65535, 16384));
      ray_queue.push_back(mk_ray(-32768, -32768, -32768, -32768, -32768, -32768,
                                 65535, 65535));
      ray_queue.push_back(mk_ray(32767, -32768, 0, -32768, 32767, 0, 16384, 65535));
      // k exactly zero: grazing at the critical angle with j = 1.
      ray_queue.push_back(mk_ray(16384, 0, 0, 0, 0, 16384, 16384, 16384));
      ray_queue.push_back(mk_ray(0, 0, 0, 0, 0, 0, 16384, 16384));
      ray_queue.push_back(mk_ray(0, 0, 0, 0, 0, 0, 65535, 0));
      ray_queue.push_back(mk_ray(-1, -1, -1, -1, -1, -1, 1, 65535));
      ray_queue.push_back(mk_ray(8192, 8192, -11585, 0, 16384, 0, 24576, 16384));
      ray_queue.push_back(mk_ray(8192, 8192, -11585, 0, 16384, 0, 16384, 24576));
   end

   // Sender.
   initial begin
      ray_in_type t;
      int gap, sent;
      req_tvalid = 0;
      req_tdata = '0;
      reset = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      sent = 0;
      while (sent < 520) begin
         if (ray_queue.size() == 0)
            ray_queue.push_back(rand_ray($urandom_range(0, 3) != 0));
         t = ray_queue.pop_front();
         // The receiver's long hold starts with this back-to-back stretch.
         if (sent == 200)
            long_hold_go = 1;
         // Idle spells in the middle of the run are skipped for a stretch.
         gap = (sent >= 200 && sent < 260) ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(negedge clock);
         end
         if (sent == 300) begin
            req_tvalid <= 0;
            do @(negedge clock); while (pending_dirs.size() != 0);
         end
         req_tdata <= {t.idx_out, t.idx_in, t.n[2], t.n[1], t.n[0],
                       t.d[2], t.d[1], t.d[0]};
         req_tvalid <= 1;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         pending_dirs.push_back(t.has_known ? t.known : refract_dir(t));
         if (t.has_known && t.known != refract_dir(t)) begin
            $display("%0t: table row expected %h, predictor %h",
                     $time, t.known, refract_dir(t));
            mismatch_count++;
         end
         sent++;
         @(negedge clock);
      end
      req_tvalid <= 0;
      stim_done = 1;
   end

   // Receiver: random stalls, plus one long hold so the pipe backs up.
   initial begin
      int gap;
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_go && !long_hold_done) begin
            rsp_tready <= 0;
            repeat (150) @(negedge clock);
            long_hold_done = 1;
         end
         gap = (cycle_count % 1000 < 150) ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Checker on every accepted result.
   always @(posedge clock) begin
      ray_out_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32],
                rsp_tuser[0], rsp_tuser[1]};
         if (pending_dirs.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            mismatch_count++;
         end else begin
            want = pending_dirs.pop_front();
            if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                got.out_z !== want.out_z || got.total_reflect !== want.total_reflect ||
                got.clipped !== want.clipped) begin
               $display("%0t: expected %h %h %h tir=%b clip=%b, actual %h %h %h tir=%b clip=%b",
                        $time, want.out_x, want.out_y, want.out_z, want.total_reflect,
                        want.clipped, got.out_x, got.out_y, got.out_z,
                        got.total_reflect, got.clipped);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      while (pending_dirs.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 20) @(posedge clock);
      if (mismatch_count == 0 && pending_dirs.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
